FILE: hw/rtl/hcp_pkg.sv
// Package: constants and helper functions for the hue cycle palette.
`default_nettype none
package hcp_pkg;

	localparam int unsigned HUE_W      = 17;
	localparam int unsigned HUE_FULL   = 92160;
	localparam int unsigned HUE_SECTOR = 15360;
	localparam int unsigned HUE_OFF_ACC   = 10240;
	localparam int unsigned HUE_OFF_MUTED = 5120;

	localparam int unsigned NUM_COLORS = 3;

	// Register indexes.
	localparam logic [7:0] REG_ANIMATE = 8'd0;
	localparam logic [7:0] REG_PERIOD  = 8'd1;

	localparam logic [15:0] PERIOD_RESET = 16'd6000;

	// Chroma c = V*S and offset m = V - c per color (fg, accent, muted).
	localparam logic [15:0] CHROMA [NUM_COLORS] = '{16'd55706, 16'd58982, 16'd16056};
	localparam logic [15:0] MOFF   [NUM_COLORS] = '{16'd9830, 16'd6554, 16'd6882};
	localparam logic [HUE_W-1:0] HUE_OFF [NUM_COLORS] =
		'{17'd0, 17'(HUE_OFF_ACC), 17'(HUE_OFF_MUTED)};

	// floor(n/15) = (n * RECIP15) >> 24, exact for n < 2^20.
	localparam logic [20:0] RECIP15 = 21'd1118482;

	function automatic logic [2:0] hue_sector(input logic [HUE_W-1:0] h);
		logic [2:0] s;
		s = 3'd0;
		if (h >= 17'(HUE_SECTOR))     s = 3'd1;
		if (h >= 17'(2 * HUE_SECTOR)) s = 3'd2;
		if (h >= 17'(3 * HUE_SECTOR)) s = 3'd3;
		if (h >= 17'(4 * HUE_SECTOR)) s = 3'd4;
		if (h >= 17'(5 * HUE_SECTOR)) s = 3'd5;
		return s;
	endfunction

	// floor(v*255/65536), saturated at 255.
	function automatic logic [7:0] chan8(input logic [16:0] v);
		logic [24:0] t;
		t = {v, 8'd0} - 25'(v);
		return (t[24:16] > 9'd255) ? 8'd255 : t[23:16];
	endfunction

	function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b);
		return {r[7:3], g[7:2], b[7:3]};
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/hue_cycle_rgb565_palette.sv
// Top level: pipelined animated hue wheel to RGB565 palette generator.
`default_nettype none
// Each accepted time stamp word yields one palette word (foreground, accent
// at +40 degrees, muted at +20 degrees) while the animate bit is set; with it
// clear the word is taken and dropped. One word enters per clock unless the
// output stalls; the pipe is 32 restoring steps for now_ms mod period_ms, one
// constant multiply, 17 steps for the hue quotient, one hue offset stage and
// four HSV stages (sector split, chroma multiply, divide by 15 through a
// reciprocal, channel packing). The whole pipe holds when the output word is
// not taken. Write configuration only while the pipe is empty.
module hue_cycle_rgb565_palette (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_idx,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] now_ms,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      foreground_color,
	output logic [15:0]      accent_color,
	output logic [15:0]      muted_color
);
	import hcp_pkg::*;

	localparam int unsigned MOD_N = 32;
	localparam int unsigned DIV_N = 17;
	localparam int unsigned PROD_ST = MOD_N;
	localparam int unsigned DIV_ST  = PROD_ST + 1;
	localparam int unsigned HUE_ST  = DIV_ST + DIV_N;
	localparam int unsigned LAT     = HUE_ST + 5;

	logic        en_q;
	logic [15:0] period_q;
	logic        adv;
	logic        per_zero;
	logic [LAT-1:0] vld_s;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q     <= 1'b0;
			period_q <= PERIOD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_ANIMATE: en_q     <= cfg_wdata[0];
				REG_PERIOD:  period_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Advance the whole pipe unless the output word is stalled.
	assign adv       = !vld_s[LAT-1] || out_ready;
	assign in_ready  = adv;
	assign out_valid = vld_s[LAT-1];
	assign per_zero  = (period_q == 16'd0);

	// Valid bits; drop words while animation is off.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[LAT-2:0], in_valid && en_q};
		end
	end

	// Phase: restoring remainder, one dividend bit per stage.
	logic [15:0] mod_rem_s [MOD_N];
	logic [31:0] mod_num_s [MOD_N];

	for (genvar k = 0; k < MOD_N; k++) begin : g_mod
		logic [15:0] prev_rem;
		logic [31:0] prev_num;
		logic [16:0] cand;
		logic [15:0] nxt;
		if (k == 0) begin : g_first
			assign prev_rem = 16'd0;
			assign prev_num = now_ms;
		end else begin : g_next
			assign prev_rem = mod_rem_s[k-1];
			assign prev_num = mod_num_s[k-1];
		end
		assign cand = {prev_rem, prev_num[MOD_N-1-k]};
		assign nxt  = (cand >= {1'b0, period_q}) ? 16'(cand - {1'b0, period_q})
			: cand[15:0];
		always_ff @(posedge clk) begin
			if (adv) begin
				mod_rem_s[k] <= nxt;
				mod_num_s[k] <= prev_num;
			end
		end
	end

	// Scale the phase to the hue wheel.
	logic [15:0] phase;
	logic [32:0] prod_s;
	assign phase = per_zero ? 16'd0 : mod_rem_s[MOD_N-1];
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s <= 33'(phase) * 33'(HUE_FULL);
		end
	end

	// Hue quotient: high bits of the product are already below the period.
	logic [15:0]      div_rem_s [DIV_N];
	logic [16:0]      div_num_s [DIV_N];
	logic [HUE_W-1:0] div_q_s   [DIV_N];

	for (genvar k = 0; k < DIV_N; k++) begin : g_div
		logic [15:0]      prev_rem;
		logic [16:0]      prev_num;
		logic [HUE_W-1:0] prev_q;
		logic [16:0]      cand;
		logic             ge;
		if (k == 0) begin : g_first
			assign prev_rem = prod_s[32:17];
			assign prev_num = prod_s[16:0];
			assign prev_q   = '0;
		end else begin : g_next
			assign prev_rem = div_rem_s[k-1];
			assign prev_num = div_num_s[k-1];
			assign prev_q   = div_q_s[k-1];
		end
		assign cand = {prev_rem, prev_num[DIV_N-1-k]};
		assign ge   = (cand >= {1'b0, period_q});
		always_ff @(posedge clk) begin
			if (adv) begin
				div_rem_s[k] <= ge ? 16'(cand - {1'b0, period_q}) : cand[15:0];
				div_num_s[k] <= prev_num;
				div_q_s[k]   <= {prev_q[HUE_W-2:0], ge};
			end
		end
	end

	// Base hue plus the per-color offsets, wrapped on the wheel.
	logic [HUE_W-1:0] base_hue;
	logic [HUE_W-1:0] hue_s [NUM_COLORS];
	assign base_hue = per_zero ? '0 : div_q_s[DIV_N-1];

	logic [2:0]  sec_s1  [NUM_COLORS];
	logic [13:0] span_s1 [NUM_COLORS];
	logic [2:0]  sec_s2  [NUM_COLORS];
	logic [29:0] prod_s2 [NUM_COLORS];
	logic [2:0]  sec_s3  [NUM_COLORS];
	logic [15:0] x_s3    [NUM_COLORS];
	logic [15:0] color_s4 [NUM_COLORS];

	for (genvar j = 0; j < NUM_COLORS; j++) begin : g_color
		logic [HUE_W-1:0] raw;
		logic [2:0]       sec;
		logic [HUE_W-1:0] frac;
		logic [41:0]      qprod;
		logic [16:0]      rv, gv, bv;
		assign raw = base_hue + HUE_OFF[j];

		always_ff @(posedge clk) begin
			if (adv) begin
				hue_s[j] <= (raw >= 17'(HUE_FULL)) ? 17'(raw - 17'(HUE_FULL)) : raw;
			end
		end

		// Sector and the triangle span.
		assign sec  = hue_sector(hue_s[j]);
		assign frac = hue_s[j] - 17'(17'(sec) * 17'(HUE_SECTOR));
		always_ff @(posedge clk) begin
			if (adv) begin
				sec_s1[j]  <= sec;
				span_s1[j] <= sec[0] ? 14'(17'(HUE_SECTOR) - frac) : frac[13:0];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sec_s2[j]  <= sec_s1[j];
				prod_s2[j] <= 30'(CHROMA[j]) * 30'(span_s1[j]);
			end
		end

		// x = floor(prod / 15360) = floor((prod >> 10) / 15).
		assign qprod = 42'(prod_s2[j][29:10]) * 42'(RECIP15);
		always_ff @(posedge clk) begin
			if (adv) begin
				sec_s3[j] <= sec_s2[j];
				x_s3[j]   <= qprod[39:24];
			end
		end

		always_comb begin
			rv = 17'(MOFF[j]);
			gv = 17'(MOFF[j]);
			bv = 17'(MOFF[j]);
			unique case (sec_s3[j])
				3'd0: begin rv = rv + 17'(CHROMA[j]); gv = gv + 17'(x_s3[j]); end
				3'd1: begin rv = rv + 17'(x_s3[j]); gv = gv + 17'(CHROMA[j]); end
				3'd2: begin gv = gv + 17'(CHROMA[j]); bv = bv + 17'(x_s3[j]); end
				3'd3: begin gv = gv + 17'(x_s3[j]); bv = bv + 17'(CHROMA[j]); end
				3'd4: begin rv = rv + 17'(x_s3[j]); bv = bv + 17'(CHROMA[j]); end
				default: begin rv = rv + 17'(CHROMA[j]); bv = bv + 17'(x_s3[j]); end
			endcase
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				color_s4[j] <= pack565(chan8(rv), chan8(gv), chan8(bv));
			end
		end
	end

	assign foreground_color = color_s4[0];
	assign accent_color     = color_s4[1];
	assign muted_color      = color_s4[2];

`ifndef ASSERT_OFF
	// A held pipe keeps every valid bit in place.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_s))
		else $error("valid bits moved during a stall");

	// Words taken while animation is off never enter the pipe.
	a_drop_disabled: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !en_q |=> !vld_s[0])
		else $error("word entered with animation off");

	// Wrapped hues stay on the wheel.
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[HUE_ST] |-> (hue_s[0] < 17'(HUE_FULL)) && (hue_s[1] < 17'(HUE_FULL))
			&& (hue_s[2] < 17'(HUE_FULL)))
		else $error("hue out of range");

	// Muted color has value 0.35, so red stays at most 11.
	a_muted_dim: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> muted_color[15:11] <= 5'd11)
		else $error("muted color too bright");
`endif

endmodule
`default_nettype wire

FILE: bench/hue_cycle_rgb565_palette_tb.sv
// Testbench for the hue cycle RGB565 palette generator.
`timescale 1ns / 1ps
module hue_cycle_rgb565_palette_tb;
	import hcp_pkg::*;

	localparam int PIPE_LAT   = 55;
	localparam int WATCH_MAX  = 20000;
	localparam int SHOW_MAX   = 10;

	typedef struct packed {
		logic [15:0] fg;
		logic [15:0] acc;
		logic [15:0] mute;
	} palette_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [7:0]  cfg_idx;
	logic [15:0] cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] now_ms;
	logic        out_valid;
	logic        out_ready;
	logic [15:0] foreground_color;
	logic [15:0] accent_color;
	logic [15:0] muted_color;

	hue_cycle_rgb565_palette u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .now_ms(now_ms),
		.out_valid(out_valid), .out_ready(out_ready),
		.foreground_color(foreground_color), .accent_color(accent_color),
		.muted_color(muted_color)
	);

	// Predictor's own copy of the configuration.
	logic        anim_en;
	logic [15:0] period;

	logic [31:0] stamp_q[$];     // time stamps waiting to be driven
	palette_t    palette_q[$];   // expected palettes, oldest first
	int          mismatches;
	int          send_idle_pct, recv_idle_pct;
	int          hold_cycles;    // long receiver hold-off, counted down by the monitor
	int          quiet_cycles;
	bit          timed_out;

	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	// HSV to RGB565 for one hue in 1/256 degree, S and V in Q16.
	function automatic logic [15:0] hsv565(input logic [16:0] hue, input logic [16:0] sat,
		input logic [16:0] val);
		logic [2:0]  sector;
		logic [31:0] frac, span, chroma, side, moff;
		logic [31:0] r, g, b;
		logic [63:0] t;
		sector = 3'(hue / HUE_SECTOR);
		frac   = hue % HUE_SECTOR;
		chroma = (32'(val) * 32'(sat)) >> 16;
		span   = sector[0] ? (HUE_SECTOR - frac) : frac;
		side   = (chroma * span) / HUE_SECTOR;
		moff   = 32'(val) - chroma;
		r = 0; g = 0; b = 0;
		case (sector)
			3'd0: begin r = chroma; g = side; end
			3'd1: begin r = side; g = chroma; end
			3'd2: begin g = chroma; b = side; end
			3'd3: begin g = side; b = chroma; end
			3'd4: begin r = side; b = chroma; end
			default: begin r = chroma; b = side; end
		endcase
		t = (64'(r + moff) * 255) >> 16; r = (t > 255) ? 255 : 32'(t);
		t = (64'(g + moff) * 255) >> 16; g = (t > 255) ? 255 : 32'(t);
		t = (64'(b + moff) * 255) >> 16; b = (t > 255) ? 255 : 32'(t);
		return {r[7:3], g[7:2], b[7:3]};
	endfunction

	// Expected palette for one accepted stamp; nothing while animation is off.
	task automatic predict_palette(input logic [31:0] stamp);
		logic [16:0] hue;
		palette_t    p;
		hue = 0;
		if (anim_en) begin
			if (period != 0)
				hue = 17'((64'(stamp % period) * HUE_FULL) / period);
			p.fg   = hsv565(hue, 17'd55706, 17'd65536);
			p.acc  = hsv565(17'((hue + HUE_OFF_ACC) % HUE_FULL), 17'd58982, 17'd65536);
			p.mute = hsv565(17'((hue + HUE_OFF_MUTED) % HUE_FULL), 17'd45875, 17'd22938);
			palette_q.push_back(p);
		end
	endtask

	// Driver: offer the queued stamps, idling at random between words.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			now_ms   <= '0;
		end else begin
			if (in_valid && in_ready) begin
				predict_palette(now_ms);
				void'(stamp_q.pop_front());
			end
			if (in_valid && !in_ready) begin
				// hold the word until it is taken
			end else if (stamp_q.size() > 0 &&
				$urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				now_ms   <= stamp_q[0];
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: compare each taken palette with the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (palette_q.size() == 0) begin
					mismatches++;
					if (mismatches <= SHOW_MAX)
						$display("unexpected palette %h %h %h", foreground_color,
							accent_color, muted_color);
				end else begin
					palette_t p;
					p = palette_q.pop_front();
					if (p.fg !== foreground_color || p.acc !== accent_color ||
						p.mute !== muted_color) begin
						mismatches++;
						if (mismatches <= SHOW_MAX)
							$display("palette mismatch: expected %h %h %h, got %h %h %h",
								p.fg, p.acc, p.mute, foreground_color, accent_color,
								muted_color);
					end
				end
			end
			if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
				out_ready   <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Watchdog: count cycles in which neither side takes a word.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCH_MAX) begin
			timed_out = 1'b1;
			$display("Some tests failed");
			$finish;
		end
	end

	// Write one register; the pipe must be empty.
	task automatic write_reg(input logic [7:0] idx, input logic [15:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		if (idx == REG_ANIMATE) anim_en = value[0];
		else if (idx == REG_PERIOD) period = value;
	endtask

	// Let every queued stamp go out and every palette come back, then drain the pipe.
	task automatic drain;
		wait (stamp_q.size() == 0 && !in_valid);
		wait (palette_q.size() == 0);
		repeat (PIPE_LAT + 5) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_stamp();
		case ($urandom_range(3))
			0: return $urandom;
			1: return 32'($urandom_range(200000));
			2: return 32'hFFFF_FFFF - $urandom_range(1000);
			default: return {1'($urandom_range(1)), 31'($urandom)};
		endcase
	endfunction

	task automatic random_phase(input int count, input logic [15:0] per, input int s_pct,
		input int r_pct);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		write_reg(REG_PERIOD, per);
		write_reg(REG_ANIMATE, 16'd1);
		repeat (count) stamp_q.push_back(rand_stamp());
		drain();
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_idx       = '0;
		cfg_wdata     = '0;
		mismatches    = 0;
		hold_cycles   = 0;
		quiet_cycles  = 0;
		timed_out     = 1'b0;
		send_idle_pct = 28;
		recv_idle_pct = 47;
		anim_en       = 1'b0;
		period        = PERIOD_RESET;
		repeat (7) @(posedge clk);
		arst_n = 1'b1;

		// Animation off after reset: stamps are taken and dropped.
		stamp_q.push_back(32'd0);
		stamp_q.push_back(32'hFFFF_FFFF);
		drain();

		// Directed: sector edges at the reset period, wheel wraps, field extremes.
		write_reg(REG_ANIMATE, 16'd1);
		for (int k = 0; k < 12; k++)
			stamp_q.push_back(32'(k * 500));
		stamp_q.push_back(32'd5999);
		stamp_q.push_back(32'd6000);
		stamp_q.push_back(32'hFFFF_FFFF);
		stamp_q.push_back(32'hAAAA_AAAA);
		stamp_q.push_back(32'h5555_5555);
		drain();
		// Zero period pins the hue at zero; one and the largest period.
		write_reg(REG_PERIOD, 16'd0);
		stamp_q.push_back(32'd12345);
		drain();
		write_reg(REG_PERIOD, 16'd1);
		stamp_q.push_back(32'hFFFF_FFFF);
		drain();
		write_reg(REG_PERIOD, 16'hFFFF);
		stamp_q.push_back(32'hFFFE);
		stamp_q.push_back(32'hFFFF_FFFF);
		drain();
		// Unknown index is ignored.
		write_reg(8'hFF, 16'h1234);

		// Long receiver hold-off while stamps keep coming, so the pipe fills up.
		write_reg(REG_PERIOD, 16'd6000);
		hold_cycles   = 300;
		repeat (100) stamp_q.push_back(rand_stamp());
		drain();

		random_phase(150, 16'($urandom_range(2, 65534)), 28, 47);
		random_phase(150, 16'($urandom_range(1, 1000)), 47, 28);
		random_phase(150, 16'd65535, 0, 0);

		// Disabled again: every stamp dropped.
		write_reg(REG_ANIMATE, 16'd0);
		repeat (10) stamp_q.push_back($urandom);
		drain();

		if (mismatches == 0 && palette_q.size() == 0 && !timed_out)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
